### rtl/clx_pkg.sv
// shared types, codes and keyword tables for the declaration lexer
`timescale 1ns / 1ps
package clx_pkg;

  localparam int DEFAULT_MAX_TEXT_LEN = 32;
  localparam int NUM_KW = 12;

  localparam logic [4:0] K_ERROR  = 5'd0;
  localparam logic [4:0] K_SLASH  = 5'd6;
  localparam logic [4:0] K_STRUCT = 5'd9;
  localparam logic [4:0] K_ENUM   = 5'd10;
  localparam logic [4:0] K_NUMBER = 5'd21;
  localparam logic [4:0] K_IDENT  = 5'd22;

  localparam logic [2:0] S_OK        = 3'd0;
  localparam logic [2:0] S_END       = 3'd1;
  localparam logic [2:0] S_NO_TAG    = 3'd2;
  localparam logic [2:0] S_UNKNOWN   = 3'd3;
  localparam logic [2:0] S_TOO_LONG  = 3'd4;
  localparam logic [2:0] S_BAD_NUM   = 3'd5;

  localparam logic [1:0] TAG_NONE   = 2'd0;
  localparam logic [1:0] TAG_STRUCT = 2'd1;
  localparam logic [1:0] TAG_ENUM   = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SLASH, PH_BLOCK, PH_BLOCK_STAR, PH_LINE,
    PH_IDENT, PH_ZERO, PH_NUMBER, PH_TAG_WS
  } phase_t;

  typedef enum logic {ST_RUN, ST_DRAIN} state_t;

  typedef struct packed {
    logic       space;
    logic       head;
    logic       digit;
    logic [4:0] pkind;
  } cls_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    cls_t       cls;
  } item_t;

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h28:   k = 5'd1;
      8'h29:   k = 5'd2;
      8'h5b:   k = 5'd3;
      8'h5d:   k = 5'd4;
      8'h2c:   k = 5'd5;
      8'h2f:   k = K_SLASH;
      8'h2a:   k = 5'd7;
      8'h3b:   k = 5'd8;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r.space = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    r.digit = (c >= 8'h30 && c <= 8'h39);
    r.head  = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || (c == 8'h5f);
    r.pkind = punct_kind(c);
    return r;
  endfunction

  // keyword text, left aligned, zero padded
  function automatic logic [63:0] kw_word(input logic [3:0] k);
    logic [63:0] w;
    unique case (k)
      4'd0:    w = {"const", 24'h0};
      4'd1:    w = "volatile";
      4'd2:    w = {"signed", 16'h0};
      4'd3:    w = "unsigned";
      4'd4:    w = {"struct", 16'h0};
      4'd5:    w = {"enum", 32'h0};
      4'd6:    w = {"void", 32'h0};
      4'd7:    w = {"char", 32'h0};
      4'd8:    w = {"int", 40'h0};
      4'd9:    w = {"long", 32'h0};
      4'd10:   w = {"float", 24'h0};
      4'd11:   w = {"double", 16'h0};
      default: w = 64'h0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    logic [3:0] n;
    unique case (k)
      4'd0, 4'd10:       n = 4'd5;
      4'd1, 4'd3:        n = 4'd8;
      4'd2, 4'd4, 4'd11: n = 4'd6;
      4'd8:              n = 4'd3;
      default:           n = 4'd4;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] kw_kind(input logic [3:0] k);
    logic [4:0] r;
    unique case (k)
      4'd4:    r = K_STRUCT;
      4'd5:    r = K_ENUM;
      4'd0:    r = 5'd11;
      4'd1:    r = 5'd12;
      4'd2:    r = 5'd13;
      4'd3:    r = 5'd14;
      4'd6:    r = 5'd15;
      4'd7:    r = 5'd16;
      4'd8:    r = 5'd17;
      4'd9:    r = 5'd18;
      4'd10:   r = 5'd19;
      4'd11:   r = 5'd20;
      default: r = K_ERROR;
    endcase
    return r;
  endfunction

  // keywords whose byte at position pos equals c
  function automatic logic [NUM_KW-1:0] kw_hit(input logic [7:0] pos, input logic [7:0] c);
    logic [NUM_KW-1:0] m;
    logic [63:0] w;
    for (int k = 0; k < NUM_KW; k++) begin
      w = kw_word(4'(k));
      m[k] = (pos < 8'd8) && (w[63 - 8*pos[2:0] -: 8] == c);
    end
    return m;
  endfunction

endpackage

### rtl/clx_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module clx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/clx_front.sv
// input side: accepts items, classifies the byte and queues them for the lexer
`timescale 1ns / 1ps
module clx_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     char_in,
  input  logic           end_of_input,
  output logic           q_valid,
  output clx_pkg::item_t q_item,
  input  logic           q_pop
);
  import clx_pkg::*;

  item_t      slots [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       do_push, do_pop;

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_item  = slots[rp];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) begin
      slots[wp] <= '{ch: char_in, eoi: end_of_input, cls: classify(char_in)};
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count out of range");
  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> cnt == $past(cnt) + 2'd1)
    else $error("queue count did not grow on push");
`endif
endmodule

### rtl/clx_back.sv
// lexer engine: phase machine, text store, keyword match and result register
`timescale 1ns / 1ps
module clx_back #(
  parameter int MAX_TEXT_LEN = clx_pkg::DEFAULT_MAX_TEXT_LEN,
  localparam int LW = $clog2(MAX_TEXT_LEN + 1),
  localparam int AW = (MAX_TEXT_LEN > 1) ? $clog2(MAX_TEXT_LEN) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  clx_pkg::item_t q_item,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [4:0]     token_kind,
  output logic [2:0]     status,
  output logic [7:0]     text_byte,
  output logic           text_valid,
  output logic           last
);
  import clx_pkg::*;

  state_t state, state_next;
  phase_t phase, phase_next;
  logic [LW-1:0] text_length, text_length_next;
  logic [1:0]    awaiting_tag, awaiting_tag_next;
  logic          after_comment, after_comment_next;
  logic [NUM_KW-1:0] kw, kw_next;
  logic [4:0]    drain_kind, drain_kind_next;
  logic [LW-1:0] idx;
  logic          dok;
  logic          ovalid;

  logic       emit, done, drain_go, fire, out_free, drain_emit, drain_last;
  logic [4:0] e_kind;
  logic [2:0] e_status;
  logic [7:0] e_byte;
  logic       e_tv, e_last;
  logic       we;
  logic [AW-1:0] waddr;
  logic [7:0] rdata;
  logic [7:0] len8;
  logic [4:0] kw_found;
  logic       at_max;

  clx_ram #(.WIDTH(8), .DEPTH(MAX_TEXT_LEN)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(q_item.ch),
    .raddr(idx[AW-1:0]), .rdata(rdata)
  );

  assign len8     = 8'(text_length);
  assign at_max   = (32'(text_length) >= MAX_TEXT_LEN);
  assign waddr    = (phase_next == PH_IDENT || phase_next == PH_ZERO ||
                     phase_next == PH_NUMBER) && text_length_next == LW'(1) ?
                    AW'(0) : text_length[AW-1:0];
  assign out_free = !ovalid || pop;
  assign empty    = !ovalid;

  always_comb begin
    kw_found = K_ERROR;
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw[k] && len8 == 8'(kw_len(4'(k)))) kw_found = kw_kind(4'(k));
    end
  end

  // one step of the phase machine on the waiting item
  always_comb begin
    emit = 1'b0; done = 1'b0; drain_go = 1'b0; we = 1'b0;
    e_kind = K_ERROR; e_status = S_OK; e_byte = 8'h0; e_tv = 1'b0; e_last = 1'b1;
    phase_next = phase; text_length_next = text_length;
    awaiting_tag_next = awaiting_tag; after_comment_next = after_comment;
    kw_next = kw; drain_kind_next = drain_kind;
    if (q_item.eoi) begin
      unique case (phase)
        PH_SLASH: begin
          emit = 1'b1; e_kind = K_SLASH; phase_next = PH_IDLE;
        end
        PH_IDENT: begin
          phase_next = PH_IDLE;
          if (awaiting_tag != TAG_NONE) begin
            drain_go = 1'b1; awaiting_tag_next = TAG_NONE;
            drain_kind_next = (awaiting_tag == TAG_STRUCT) ? K_STRUCT : K_ENUM;
          end else if (kw_found == K_STRUCT || kw_found == K_ENUM) begin
            awaiting_tag_next = (kw_found == K_STRUCT) ? TAG_STRUCT : TAG_ENUM;
            phase_next = PH_TAG_WS;
          end else if (kw_found != K_ERROR) begin
            emit = 1'b1; e_kind = kw_found;
          end else begin
            drain_go = 1'b1; drain_kind_next = K_IDENT;
          end
        end
        PH_NUMBER: begin
          drain_go = 1'b1; drain_kind_next = K_NUMBER; phase_next = PH_IDLE;
        end
        default: begin
          emit = 1'b1; e_status = S_END; done = 1'b1;
          phase_next = PH_IDLE; text_length_next = '0;
          awaiting_tag_next = TAG_NONE; after_comment_next = 1'b0;
        end
      endcase
    end else begin
      unique case (phase)
        PH_SLASH: begin
          if (q_item.ch == 8'h2a) begin
            phase_next = PH_BLOCK; done = 1'b1;
          end else if (q_item.ch == 8'h2f) begin
            phase_next = PH_LINE; done = 1'b1;
          end else begin
            emit = 1'b1; e_kind = K_SLASH; phase_next = PH_IDLE;
          end
        end
        PH_BLOCK: begin
          done = 1'b1;
          if (q_item.ch == 8'h2a) phase_next = PH_BLOCK_STAR;
        end
        PH_BLOCK_STAR: begin
          done = 1'b1;
          if (q_item.ch == 8'h2f) begin
            phase_next = PH_IDLE; after_comment_next = 1'b1;
          end else if (q_item.ch != 8'h2a) begin
            phase_next = PH_BLOCK;
          end
        end
        PH_LINE: begin
          done = 1'b1;
          if (q_item.ch == 8'h0a) begin
            phase_next = PH_IDLE; after_comment_next = 1'b1;
          end
        end
        PH_IDENT: begin
          if (q_item.cls.head || q_item.cls.digit) begin
            if (at_max) begin
              emit = 1'b1; e_status = S_TOO_LONG;
              awaiting_tag_next = TAG_NONE; phase_next = PH_IDLE;
            end else begin
              we = 1'b1; done = 1'b1; text_length_next = text_length + LW'(1);
              kw_next = kw & kw_hit(len8, q_item.ch);
            end
          end else begin
            phase_next = PH_IDLE;
            if (awaiting_tag != TAG_NONE) begin
              drain_go = 1'b1; awaiting_tag_next = TAG_NONE;
              drain_kind_next = (awaiting_tag == TAG_STRUCT) ? K_STRUCT : K_ENUM;
            end else if (kw_found == K_STRUCT || kw_found == K_ENUM) begin
              awaiting_tag_next = (kw_found == K_STRUCT) ? TAG_STRUCT : TAG_ENUM;
              phase_next = PH_TAG_WS;
            end else if (kw_found != K_ERROR) begin
              emit = 1'b1; e_kind = kw_found;
            end else begin
              drain_go = 1'b1; drain_kind_next = K_IDENT;
            end
          end
        end
        PH_ZERO: begin
          done = 1'b1;
          if (q_item.ch == 8'h78 || q_item.ch == 8'h58) begin
            phase_next = PH_NUMBER;
          end else begin
            emit = 1'b1; e_status = S_BAD_NUM; phase_next = PH_IDLE;
          end
        end
        PH_NUMBER: begin
          if (q_item.cls.digit) begin
            if (at_max) begin
              emit = 1'b1; e_status = S_TOO_LONG; phase_next = PH_IDLE;
            end else begin
              we = 1'b1; done = 1'b1; text_length_next = text_length + LW'(1);
            end
          end else begin
            drain_go = 1'b1; drain_kind_next = K_NUMBER; phase_next = PH_IDLE;
          end
        end
        PH_TAG_WS: begin
          if (q_item.cls.space) begin
            done = 1'b1;
          end else if (q_item.cls.head) begin
            we = 1'b1; done = 1'b1; text_length_next = LW'(1); phase_next = PH_IDENT;
            kw_next = kw_hit(8'h0, q_item.ch);
          end else begin
            emit = 1'b1; e_status = S_NO_TAG;
            awaiting_tag_next = TAG_NONE; phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE; done = 1'b1;
          if (!q_item.cls.space) begin
            after_comment_next = 1'b0;
            if (after_comment && q_item.ch == 8'h2f) begin
              emit = 1'b1; e_kind = K_SLASH;
            end else if (q_item.ch == 8'h2f) begin
              phase_next = PH_SLASH;
            end else if (q_item.cls.head || q_item.cls.digit) begin
              we = 1'b1; text_length_next = LW'(1);
              kw_next = kw_hit(8'h0, q_item.ch);
              phase_next = !q_item.cls.digit ? PH_IDENT :
                           (q_item.ch == 8'h30) ? PH_ZERO : PH_NUMBER;
            end else if (q_item.cls.pkind != K_ERROR) begin
              emit = 1'b1; e_kind = q_item.cls.pkind;
            end else begin
              emit = 1'b1; e_status = S_UNKNOWN; e_byte = q_item.ch; e_tv = 1'b1;
            end
          end
        end
      endcase
    end
  end

  assign fire       = (state == ST_RUN) && q_valid && (!emit || out_free);
  assign q_pop      = fire && done;
  assign drain_emit = (state == ST_DRAIN) && dok && out_free;
  assign drain_last = (idx + LW'(1) == text_length);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN:   if (fire && drain_go) state_next = ST_DRAIN;
      ST_DRAIN: if (drain_emit && drain_last) state_next = ST_RUN;
      default:  state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      phase <= PH_IDLE;
      text_length <= '0;
      awaiting_tag <= TAG_NONE;
      after_comment <= 1'b0;
      ovalid <= 1'b0;
      dok <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      if (fire) begin
        phase <= phase_next;
        text_length <= text_length_next;
        awaiting_tag <= awaiting_tag_next;
        after_comment <= after_comment_next;
      end
      if (fire && drain_go) begin
        idx <= '0;
        dok <= 1'b0;
      end else if (drain_emit) begin
        idx <= idx + LW'(1);
        dok <= 1'b0;
      end else begin
        dok <= (state == ST_DRAIN);
      end
      if ((fire && emit) || drain_emit) ovalid <= 1'b1;
      else if (pop) ovalid <= 1'b0;
    end
    if (fire) begin
      kw <= kw_next;
      drain_kind <= drain_kind_next;
    end
    if (fire && emit) begin
      token_kind <= e_kind; status <= e_status; text_byte <= e_byte;
      text_valid <= e_tv; last <= e_last;
    end else if (drain_emit) begin
      token_kind <= drain_kind; status <= S_OK; text_byte <= rdata;
      text_valid <= 1'b1; last <= drain_last;
    end
  end

`ifndef SYNTHESIS
  a_drain_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> text_length != '0)
    else $error("text drain with empty store");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && !pop |=> ovalid && $stable(token_kind) && $stable(text_byte))
    else $error("waiting result changed");
  a_no_pop_in_drain: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> !q_pop)
    else $error("item retired during text drain");
`endif
endmodule

### rtl/c_declaration_lexer.sv
// top level of the streaming c declaration lexer
`timescale 1ns / 1ps
// Streaming lexer for C declarations. Each item is one character byte, or an
// end-of-input mark that flushes a pending token and then reports end. Items
// go into a two-entry queue where each byte is classified; the lexer engine
// behind it takes one queued item per cycle while it is not draining text and
// its output register is free (an item that ends one token is kept and taken
// again to start the next). A finished identifier, tag or number comes out
// one text byte per result, read from the text store ram; the engine takes no
// item while draining; the front keeps taking items until its queue fills.
// Results wait in an output register, so a stalled consumer only holds the
// engine. Keywords are recognized on the fly as bytes are stored, and struct
// or enum take the next identifier as their tag text. Errors come out as
// kind 0 with a status code. No clearing pass is needed after reset.
module c_declaration_lexer #(
  parameter int MAX_TEXT_LEN = clx_pkg::DEFAULT_MAX_TEXT_LEN
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in,
  input  logic       end_of_input,
  output logic       empty,
  input  logic       pop,
  output logic [4:0] token_kind,
  output logic [2:0] status,
  output logic [7:0] text_byte,
  output logic       text_valid,
  output logic       last
);
  import clx_pkg::*;

  // classified items between the front queue and the engine
  logic  q_valid, q_pop;
  item_t q_item;

  clx_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .char_in(char_in), .end_of_input(end_of_input),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  clx_back #(.MAX_TEXT_LEN(MAX_TEXT_LEN)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .empty(empty), .pop(pop), .token_kind(token_kind), .status(status),
    .text_byte(text_byte), .text_valid(text_valid), .last(last)
  );
endmodule
